/* hw/rtl/p1305_pkg.sv */
`default_nettype none

package p1305_pkg;

    localparam int WORD_W      = 64;
    localparam int LEN_W       = 5;
    localparam int BLOCK_BYTES = 16;
    localparam int MSG_W       = 129;   // 128 data bits plus the 2^128 bit
    localparam int SUM_W       = 133;   // accumulator plus message, before folding
    localparam int X_W         = 131;   // folded multiplicand, just above 2^130
    localparam int H_W         = 132;   // loosely reduced accumulator
    localparam int R_W         = 124;   // clamped r has its top four bits clear
    localparam int TAG_W       = 128;
    localparam int CNT_W       = 7;

    localparam logic [127:0] R_CLAMP = 128'h0ffffffc_0ffffffc_0ffffffc_0fffffff;

    typedef enum logic [1:0] {
        REG_R_LOW  = 2'd0,
        REG_R_HIGH = 2'd1,
        REG_S_LOW  = 2'd2,
        REG_S_HIGH = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_MUL,
        ST_FSTART,
        ST_FWAIT,
        ST_EMIT
    } mac_state_t;

    typedef struct packed {
        logic             start;
        logic [X_W-1:0]   x;
        logic [R_W-1:0]   r;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [H_W-1:0]   prod;
    } mul_rsp_t;

    typedef struct packed {
        logic             start;
        logic [H_W-1:0]   h;
        logic [TAG_W-1:0] s;
    } fin_req_t;

    typedef struct packed {
        logic             done;
        logic [TAG_W-1:0] tag;
    } fin_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/p1305_if.sv */
`default_nettype none

interface p1305_in_if;
    logic                         valid;
    logic                         ready;
    logic [p1305_pkg::WORD_W-1:0] block_low;
    logic [p1305_pkg::WORD_W-1:0] block_high;
    logic [p1305_pkg::LEN_W-1:0]  byte_count;
    logic                         last_block;

    modport source (output valid, block_low, block_high, byte_count, last_block,
                    input ready);
    modport sink   (input valid, block_low, block_high, byte_count, last_block,
                    output ready);
endinterface

interface p1305_out_if;
    logic                         valid;
    logic                         ready;
    logic [p1305_pkg::WORD_W-1:0] tag_low;
    logic [p1305_pkg::WORD_W-1:0] tag_high;
    logic                         status;

    modport source (output valid, tag_low, tag_high, status, input ready);
    modport sink   (input valid, tag_low, tag_high, status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/poly1305_mac_unit.sv */
`default_nettype none

// Channel   Dir  Payload                                        Handshake
// msg       in   block_low, block_high, byte_count, last_block  valid/ready
// tag       out  tag_low, tag_high, status                      valid/ready
// cfg       in   cfg_index, cfg_wdata                           cfg_we, no wait
//
// A block that is absorbed is added to h, folded, then multiplied by r in
// 124 steps of the bit-serial multiplier, one per bit of clamped r, and the
// product is written back to h.
// A last item then also goes through the finish and the output register load.
// An item with a zero count that is not last is taken and leaves h as it is.
// Reset clears h, the key registers and all control state.
// msg is taken only while the block is idle; a finished tag waits in the
// output register and stalls the block only when the next result is due.
module poly1305_mac_unit
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [p1305_pkg::WORD_W-1:0] cfg_wdata,
    p1305_in_if.sink                          msg,
    p1305_out_if.source                       tag
);

    p1305_pkg::mac_state_t             state_reg, state_next;

    logic [p1305_pkg::WORD_W-1:0]      r_low_reg, r_high_reg, s_low_reg, s_high_reg;
    logic [p1305_pkg::H_W-1:0]         h_reg, h_next;
    logic [p1305_pkg::SUM_W-1:0]       sum_reg;
    logic                              last_reg, err_reg;
    logic                              out_valid_reg, out_valid_next;
    logic [p1305_pkg::TAG_W-1:0]       out_tag_reg;
    logic                              out_status_reg;

    logic [p1305_pkg::LEN_W-1:0]       n_sat;
    logic                              full_blk;
    logic                              absorb;
    logic                              short_err;
    logic [p1305_pkg::MSG_W-1:0]       m;
    logic [127:0]                      raw;
    logic [p1305_pkg::SUM_W-1:0]       sum_next;
    logic                              accept;
    logic                              emit_ok;
    logic [2:0]                        sum_top;
    logic [5:0]                        five_top;
    logic [127:0]                      r_clamped;

    p1305_pkg::mul_req_t               mul_req;
    p1305_pkg::mul_rsp_t               mul_rsp;
    p1305_pkg::fin_req_t               fin_req;
    p1305_pkg::fin_rsp_t               fin_rsp;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_low_reg  <= '0;
            r_high_reg <= '0;
            s_low_reg  <= '0;
            s_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (p1305_pkg::cfg_reg_t'(cfg_index))
                p1305_pkg::REG_R_LOW:  r_low_reg  <= cfg_wdata;
                p1305_pkg::REG_R_HIGH: r_high_reg <= cfg_wdata;
                p1305_pkg::REG_S_LOW:  s_low_reg  <= cfg_wdata;
                p1305_pkg::REG_S_HIGH: s_high_reg <= cfg_wdata;
                default:               r_low_reg  <= r_low_reg;
            endcase
        end
    end

    // Message padding: bytes past the count are dropped, a short block gets
    // 0x01 right after its data, a full block gets the 2^128 bit.
    always_comb
    begin
        raw      = {msg.block_high, msg.block_low};
        n_sat    = (msg.byte_count > p1305_pkg::LEN_W'(p1305_pkg::BLOCK_BYTES))
                   ? p1305_pkg::LEN_W'(p1305_pkg::BLOCK_BYTES) : msg.byte_count;
        full_blk = (n_sat == p1305_pkg::LEN_W'(p1305_pkg::BLOCK_BYTES));
        for (int i = 0; i < p1305_pkg::BLOCK_BYTES; i++)
        begin
            if (p1305_pkg::LEN_W'(i) < n_sat)
            begin
                m[8*i +: 8] = raw[8*i +: 8];
            end
            else if (p1305_pkg::LEN_W'(i) == n_sat)
            begin
                m[8*i +: 8] = 8'h01;
            end
            else
            begin
                m[8*i +: 8] = 8'h00;
            end
        end
        m[p1305_pkg::MSG_W-1] = full_blk;
        absorb    = full_blk || (msg.last_block && (n_sat != '0));
        short_err = !msg.last_block && !full_blk && (n_sat != '0);
        sum_next  = {1'b0, h_reg} + {{(p1305_pkg::SUM_W-p1305_pkg::MSG_W){1'b0}}, m};
    end

    // Fold bits at 2^130 and above of h + m as 5 per unit.
    always_comb
    begin
        sum_top   = sum_reg[p1305_pkg::SUM_W-1 -: 3];
        five_top  = {1'b0, sum_top, 2'b00} + {3'b000, sum_top};
        r_clamped = {r_high_reg, r_low_reg} & p1305_pkg::R_CLAMP;
        mul_req.start = (state_reg == p1305_pkg::ST_FOLD);
        mul_req.x     = {1'b0, sum_reg[p1305_pkg::X_W-2:0]}
                        + {{(p1305_pkg::X_W-6){1'b0}}, five_top};
        mul_req.r     = r_clamped[p1305_pkg::R_W-1:0];
        fin_req.start = (state_reg == p1305_pkg::ST_FSTART);
        fin_req.h     = h_reg;
        fin_req.s     = {s_high_reg, s_low_reg};
    end

    p1305_modmul u_modmul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    p1305_final u_final
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fin_req),
        .rsp   (fin_rsp)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            p1305_pkg::ST_IDLE:
            begin
                if (msg.valid)
                begin
                    if (absorb)
                    begin
                        state_next = p1305_pkg::ST_FOLD;
                    end
                    else if (msg.last_block)
                    begin
                        state_next = p1305_pkg::ST_FSTART;
                    end
                    else if (short_err)
                    begin
                        state_next = p1305_pkg::ST_EMIT;
                    end
                end
            end
            p1305_pkg::ST_FOLD:
            begin
                state_next = p1305_pkg::ST_MUL;
            end
            p1305_pkg::ST_MUL:
            begin
                if (mul_rsp.done)
                begin
                    state_next = last_reg ? p1305_pkg::ST_FSTART : p1305_pkg::ST_IDLE;
                end
            end
            p1305_pkg::ST_FSTART:
            begin
                state_next = p1305_pkg::ST_FWAIT;
            end
            p1305_pkg::ST_FWAIT:
            begin
                if (fin_rsp.done)
                begin
                    state_next = p1305_pkg::ST_EMIT;
                end
            end
            p1305_pkg::ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = p1305_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = p1305_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        accept  = (state_reg == p1305_pkg::ST_IDLE) && msg.valid;
        emit_ok = (state_reg == p1305_pkg::ST_EMIT) && (!out_valid_reg || tag.ready);

        h_next = h_reg;
        if (mul_rsp.done)
        begin
            h_next = mul_rsp.prod;
        end
        else if (emit_ok && !err_reg)
        begin
            h_next = '0;
        end

        out_valid_next = out_valid_reg;
        if (emit_ok)
        begin
            out_valid_next = 1'b1;
        end
        else if (tag.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= p1305_pkg::ST_IDLE;
            h_reg         <= '0;
            last_reg      <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                last_reg <= msg.last_block;
                err_reg  <= short_err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg <= sum_next;
        end
        if (emit_ok)
        begin
            out_tag_reg    <= err_reg ? '0 : fin_rsp.tag;
            out_status_reg <= err_reg;
        end
    end

    assign msg.ready    = (state_reg == p1305_pkg::ST_IDLE);
    assign tag.valid    = out_valid_reg;
    assign tag.tag_low  = out_tag_reg[p1305_pkg::WORD_W-1:0];
    assign tag.tag_high = out_tag_reg[p1305_pkg::TAG_W-1:p1305_pkg::WORD_W];
    assign tag.status   = out_status_reg;

    a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == p1305_pkg::ST_MUL))
        else $error("multiplier finished outside the multiply state");

    a_fin_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        fin_rsp.done |-> (state_reg == p1305_pkg::ST_FWAIT))
        else $error("finish stage completed outside its wait state");

    a_err_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tag.valid && tag.status) |-> ((tag.tag_low == '0) && (tag.tag_high == '0)))
        else $error("rejected item carries a nonzero tag");

    a_h_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_ok && !err_reg) |=> (h_reg == '0))
        else $error("accumulator not cleared after a tag");

endmodule

`default_nettype wire

/* hw/rtl/p1305_modmul.sv */
`default_nettype none

// Bit-serial Horner multiplier modulo 2^130-5. The bits of r leave a shift
// register most significant first; each cycle doubles the accumulator and
// adds x when the bit is set. Bits at 2^130 and above are folded back in as
// 5 per unit at the next step, so the accumulator stays below 2^132.
module p1305_modmul
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire p1305_pkg::mul_req_t req,
    output p1305_pkg::mul_rsp_t      rsp
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [p1305_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [p1305_pkg::H_W-1:0]           acc_reg, acc_next;
    logic [p1305_pkg::X_W-1:0]           x_reg, x_next;
    logic [p1305_pkg::R_W-1:0]           rsh_reg, rsh_next;

    logic [1:0]                          top;
    logic [4:0]                          ten_top;
    logic [p1305_pkg::H_W-1:0]           addend;
    logic [p1305_pkg::H_W-1:0]           step;

    always_comb
    begin
        top     = acc_reg[p1305_pkg::H_W-1 -: 2];
        ten_top = {top, 3'b000} + {2'b00, top, 1'b0};
        addend  = rsh_reg[p1305_pkg::R_W-1] ? {1'b0, x_reg} : '0;
        step    = {1'b0, acc_reg[p1305_pkg::H_W-3:0], 1'b0} + addend
                  + {{(p1305_pkg::H_W-5){1'b0}}, ten_top};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        rsh_next  = rsh_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = p1305_pkg::CNT_W'(p1305_pkg::R_W);
            acc_next  = '0;
            x_next    = req.x;
            rsh_next  = req.r;
        end
        else if (busy_reg)
        begin
            acc_next = step;
            rsh_next = {rsh_reg[p1305_pkg::R_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == p1305_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        rsh_reg <= rsh_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

`default_nettype wire

/* hw/rtl/p1305_final.sv */
`default_nettype none

// Three-stage finish: fold the bits above 2^130, subtract p once if needed,
// then add s modulo 2^128.
module p1305_final
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire p1305_pkg::fin_req_t req,
    output p1305_pkg::fin_rsp_t      rsp
);

    logic                              v1_reg, v2_reg, v3_reg;
    logic [p1305_pkg::X_W-1:0]         f_reg, f_next;
    logic [p1305_pkg::TAG_W-1:0]       s_reg;
    logic [p1305_pkg::TAG_W-1:0]       red_reg, red_next;
    logic [p1305_pkg::TAG_W-1:0]       tag_reg, tag_next;

    logic [1:0]                        top;
    logic [3:0]                        five_top;
    logic [p1305_pkg::X_W-1:0]         g;

    always_comb
    begin
        top      = req.h[p1305_pkg::H_W-1 -: 2];
        five_top = {top, 2'b00} + {2'b00, top};
        f_next   = {1'b0, req.h[p1305_pkg::X_W-2:0]}
                   + {{(p1305_pkg::X_W-4){1'b0}}, five_top};
        // f stays below 2p, so f + 5 reaching 2^130 means f >= p.
        g        = f_reg + p1305_pkg::X_W'(5);
        red_next = g[p1305_pkg::X_W-1] ? g[p1305_pkg::TAG_W-1:0]
                                        : f_reg[p1305_pkg::TAG_W-1:0];
        tag_next = red_reg + s_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            f_reg <= f_next;
            s_reg <= req.s;
        end
        if (v1_reg)
        begin
            red_reg <= red_next;
        end
        if (v2_reg)
        begin
            tag_reg <= tag_next;
        end
    end

    assign rsp.done = v3_reg;
    assign rsp.tag  = tag_reg;

endmodule

`default_nettype wire

/* tb/sv/poly1305_mac_unit_tb.sv */
`timescale 1ns / 1ps

module poly1305_mac_unit_tb;

    localparam bit [129:0] POLY_PRIME  = 130'h3_ffff_ffff_ffff_ffff_ffff_ffff_ffff_fffb;
    localparam bit [127:0] R_KEEP_MASK = 128'h0ffffffc_0ffffffc_0ffffffc_0fffffff;
    localparam bit [63:0]  ONES        = 64'hffff_ffff_ffff_ffff;
    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 250;

    typedef struct {
        bit [63:0] lo;
        bit [63:0] hi;
        bit        status;
    } tag_item_t;

    class tag_scoreboard;
        bit [129:0] acc_h;
        bit [63:0]  key [4];
        tag_item_t  pending_tags [$];
        int         mismatches;

        function void set_key(p1305_pkg::cfg_reg_t idx, bit [63:0] value);
            key[idx] = value;
        endfunction

        // Keeps h fully reduced; the block's loosely reduced h gives the same tag.
        function void absorb(bit [128:0] m);
            bit [263:0] prod;
            bit [127:0] r;
            r = {key[p1305_pkg::REG_R_HIGH], key[p1305_pkg::REG_R_LOW]} & R_KEEP_MASK;
            prod = (264'(acc_h) + 264'(m)) * 264'(r);
            acc_h = 130'(prod % 264'(POLY_PRIME));
        endfunction

        function void note_block(bit [63:0] lo, bit [63:0] hi, bit [4:0] cnt, bit last);
            bit [127:0] data;
            bit [127:0] keep;
            bit [129:0] tag_sum;
            tag_item_t  t;
            int         n;
            data = {hi, lo};
            n = int'(cnt);
            if (n > 16)
                n = 16;
            if (!last)
            begin
                if (n == 16)
                    absorb({1'b1, data});
                else if (n != 0)
                begin
                    t.lo = '0;
                    t.hi = '0;
                    t.status = 1'b1;
                    pending_tags.push_back(t);
                end
                return;
            end
            if (n == 16)
                absorb({1'b1, data});
            else if (n != 0)
            begin
                // A short final block gets a 0x01 byte right after its data.
                keep = (128'd1 << (8 * n)) - 128'd1;
                absorb({1'b0, data & keep} | (129'd1 << (8 * n)));
            end
            tag_sum = acc_h
                      + {2'b00, key[p1305_pkg::REG_S_HIGH], key[p1305_pkg::REG_S_LOW]};
            t.lo = tag_sum[63:0];
            t.hi = tag_sum[127:64];
            t.status = 1'b0;
            pending_tags.push_back(t);
            acc_h = '0;
        endfunction

        function void check_tag(logic [63:0] lo, logic [63:0] hi, logic status);
            tag_item_t want;
            if (pending_tags.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected tag item: low %h high %h status %b",
                             lo, hi, status);
                return;
            end
            want = pending_tags.pop_front();
            if (lo !== want.lo || hi !== want.hi || status !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tag mismatch: expected %h %h status %b, got %h %h status %b",
                             want.hi, want.lo, want.status, hi, lo, status);
            end
        endfunction

        function int outstanding();
            return pending_tags.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_wdata;

    p1305_in_if  msg_ch ();
    p1305_out_if tag_ch ();

    tag_scoreboard sb = new;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit msg_up = 1'b0;
    int items_sent = 0;
    int rx_hold = 0;
    int idle_cycles = 0;

    poly1305_mac_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .msg       (msg_ch),
        .tag       (tag_ch)
    );

    always #5 clk = ~clk;

    function automatic bit [63:0] rand_word();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return ONES;
        if (pick == 1)
            return '0;
        return {$urandom, $urandom};
    endfunction

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(p1305_pkg::cfg_reg_t idx, bit [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_key(idx, value);
    endtask

    task automatic load_key(bit [63:0] r_lo, bit [63:0] r_hi, bit [63:0] s_lo, bit [63:0] s_hi);
        write_reg(p1305_pkg::REG_R_LOW, r_lo);
        write_reg(p1305_pkg::REG_R_HIGH, r_hi);
        write_reg(p1305_pkg::REG_S_LOW, s_lo);
        write_reg(p1305_pkg::REG_S_HIGH, s_hi);
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(bit [63:0] lo, bit [63:0] hi, bit [4:0] cnt, bit last);
        int gap;
        msg_ch.valid <= 1'b1;
        msg_ch.block_low <= lo;
        msg_ch.block_high <= hi;
        msg_ch.byte_count <= cnt;
        msg_ch.last_block <= last;
        msg_up = 1'b1;
        @(posedge clk);
        while (msg_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_block(lo, hi, cnt, last);
        items_sent++;
        gap = tx_steady ? 0 : gap_len();
        if (gap > 0)
        begin
            msg_ch.valid <= 1'b0;
            msg_up = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Full blocks that yield no result may still be in flight after the
    // last tag, so settle for longer than one absorb before going on.
    task automatic drain();
        if (msg_up)
        begin
            msg_ch.valid <= 1'b0;
            msg_up = 1'b0;
        end
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            tag_ch.ready <= 1'b0;
        end
        else
        begin
            tag_ch.ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 5) == 0)
                rx_hold = gap_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && tag_ch.valid && tag_ch.ready)
            sb.check_tag(tag_ch.tag_low, tag_ch.tag_high, tag_ch.status);
    end

    always @(posedge clk)
    begin
        if ((msg_ch.valid && msg_ch.ready) || (tag_ch.valid && tag_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int phase;
        int phase_start;
        int nfull;
        int pick;
        bit [4:0] cnt;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= p1305_pkg::REG_R_LOW;
        cfg_wdata <= '0;
        msg_ch.valid <= 1'b0;
        msg_ch.block_low <= '0;
        msg_ch.block_high <= '0;
        msg_ch.byte_count <= '0;
        msg_ch.last_block <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_key(rand_word(), rand_word(), rand_word(), rand_word());
        // Empty message: the tag is just s.
        send_item('0, '0, 5'd0, 1'b1);
        send_item(ONES, ONES, 5'd16, 1'b0);
        send_item('0, '0, 5'd16, 1'b0);
        send_item(ONES, ONES, 5'd16, 1'b1);
        // Short blocks that are not last are rejected; a zero count is a no-op.
        send_item(rand_word(), rand_word(), 5'd1, 1'b0);
        send_item(rand_word(), rand_word(), 5'd15, 1'b0);
        send_item(rand_word(), rand_word(), 5'd0, 1'b0);
        send_item(ONES, ONES, 5'd1, 1'b1);
        send_item(ONES, ONES, 5'd7, 1'b1);
        send_item(ONES, ONES, 5'd8, 1'b1);
        send_item(ONES, ONES, 5'd9, 1'b1);
        send_item(ONES, ONES, 5'd15, 1'b1);
        // Counts above sixteen saturate.
        send_item(ONES, ONES, 5'd17, 1'b0);
        send_item(ONES, ONES, 5'd31, 1'b1);
        send_item(rand_word(), rand_word(), 5'd16, 1'b0);
        send_item(rand_word(), rand_word(), 5'd0, 1'b1);
        drain();

        load_key(ONES, ONES, ONES, ONES);
        send_item(ONES, ONES, 5'd16, 1'b0);
        send_item(ONES, ONES, 5'd16, 1'b0);
        send_item(ONES, ONES, 5'd16, 1'b1);
        send_item(ONES, ONES, 5'd3, 1'b1);
        drain();

        load_key('0, '0, '0, '0);
        send_item(ONES, ONES, 5'd16, 1'b1);
        send_item(rand_word(), rand_word(), 5'd12, 1'b1);
        drain();

        for (phase = 0; phase < 6; phase++)
        begin
            load_key(rand_word(), rand_word(), rand_word(), rand_word());
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                tx_steady = ($urandom_range(0, 7) == 0);
                rx_steady = ($urandom_range(0, 7) == 0);
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    send_item(rand_word(), rand_word(), 5'($urandom_range(0, 31)),
                              1'($urandom_range(0, 1)));
                else
                begin
                    nfull = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10)
                                                        : $urandom_range(0, 3);
                    repeat (nfull)
                    begin
                        cnt = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31)) : 5'd16;
                        send_item(rand_word(), rand_word(), cnt, 1'b0);
                    end
                    // A broken message: a short or empty block in the middle.
                    if (pick == 1)
                        send_item(rand_word(), rand_word(), 5'($urandom_range(0, 15)), 1'b0);
                    cnt = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                                      : 5'($urandom_range(0, 16));
                    send_item(rand_word(), rand_word(), cnt, 1'b1);
                end
                if ($urandom_range(0, 29) == 0)
                    drain();
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/p1305_pkg.sv
hw/rtl/p1305_if.sv
hw/rtl/p1305_modmul.sv
hw/rtl/p1305_final.sv
hw/rtl/poly1305_mac_unit.sv
tb/sv/poly1305_mac_unit_tb.sv
